// ===== hw/rtl/rational_arith_unit_macros.svh =====
// ----------------------------------------------------------------------------
// rational arithmetic unit assertion macros
// shared property wrappers on the block clock, with or without reset disable
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// checked only out of reset
`define RAU_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rational_arith_unit: property failed");

// checked at every edge, reset included
`define RAU_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("rational_arith_unit: property failed");

`endif

// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// commands, sequencer states and fixed widths of the rational arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned OUT_W = 33;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CMP = 3'd4,
    CMD_RED = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_MAG,
    ST_EVEN,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_SIGN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit
// add, subtract, multiply, divide, compare or reduce two signed fractions
//
// input channel: in_valid_i / in_stall_o carry command and a, b fractions.
// output channel: out_valid_o / out_stall_i carry the reduced numerator and
// denominator plus the compare and zero-denominator flags, one item per input.
// one item is worked on at a time; in_stall_o is high from the cycle after an
// accept until the result has moved into the output register.
// sequence: compare and unused commands go from idle straight to done.
// arithmetic first forms the cross products on the shared multiplier;
// then it and reduce run sign handling, the binary gcd on IW bits (IW =
// 2*WIDTH+1, at most 64) and, when the odd part of the gcd is above one,
// the one-bit restoring divider; a zero numerator or denominator skips both.
// the gcd loop and the divider each take one subtract/compare step per cycle.
// reset clears the sequencer and the output valid; no item is in flight.
// while the receiver stalls the result is held in the output register, and a
// new item is still accepted and worked on until it needs that register.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit #(
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic        [rau_pkg::CMD_W-1:0]    command_i,
  input  wire logic signed [WIDTH-1:0]             a_num_i,
  input  wire logic signed [WIDTH-1:0]             a_den_i,
  input  wire logic signed [WIDTH-1:0]             b_num_i,
  input  wire logic signed [WIDTH-1:0]             b_den_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed      [rau_pkg::OUT_W-1:0]    res_num_o,
  output logic signed      [rau_pkg::OUT_W-1:0]    res_den_o,
  output logic                                     is_equal_o,
  output logic                                     zero_den_error_o
);

  import rau_pkg::*;

  localparam int unsigned IW = (2 * WIDTH + 1 > 64) ? 64 : 2 * WIDTH + 1;
  localparam int unsigned PW = 2 * WIDTH;
  localparam int unsigned CW = $clog2(IW);

  state_e state_q, state_d;

  logic        [CMD_W-1:0] cmd_q, cmd_d;
  logic signed [WIDTH-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic        [1:0]       step_q, step_d;
  logic signed [PW-1:0]    p_q, p_d;
  logic        [IW-1:0]    n_q, n_d, d_q, d_d;
  logic        [IW-1:0]    x_q, x_d, y_q, y_d;
  logic        [IW-1:0]    rem_q, rem_d, quo_q, quo_d;
  logic        [CW-1:0]    cnt_q, cnt_d;
  logic                    neg_n_q, neg_n_d, neg_d_q, neg_d_d;
  logic                    eq_q, eq_d, err_q, err_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] out_num_q, out_num_d, out_den_q, out_den_d;
  logic                    out_eq_q, out_eq_d, out_err_q, out_err_d;

  logic                    in_accept;
  logic                    out_free;
  logic                    in_arith;
  logic                    last_bit;

  logic signed [WIDTH-1:0] mul_a, mul_b;
  logic signed [PW-1:0]    prod;
  logic        [IW-1:0]    p_ext;

  logic        [IW:0]      trial;
  logic                    div_ge;
  logic        [IW-1:0]    rem_next, quo_next;
  logic        [IW-1:0]    diff_xy, diff_yx;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_arith  = command_i inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};
  assign last_bit  = (cnt_q == CW'(IW - 1));

  // shared multiplier operand select
  always_comb begin
    case (step_q)
      2'd0: begin
        mul_a = an_q;
        mul_b = (cmd_q == CMD_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = (cmd_q == CMD_DIV) ? bn_q : bd_q;
      end
    endcase
  end

  assign prod  = PW'(mul_a) * PW'(mul_b);
  assign p_ext = IW'(p_q);

  // one-bit restoring divide step, divisor is the odd gcd in x_q
  assign trial    = {rem_q, quo_q[IW-1]};
  assign div_ge   = (trial >= {1'b0, x_q});
  assign rem_next = div_ge ? IW'(trial - {1'b0, x_q}) : IW'(trial);
  assign quo_next = {quo_q[IW-2:0], div_ge};

  assign diff_xy = x_q - y_q;
  assign diff_yx = y_q - x_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_arith) begin
            state_d = ST_MUL;
          end else if (command_i == CMD_RED) begin
            state_d = ST_CHECK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        if (step_q == 2'd3) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (d_q == '0 || n_q == '0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MAG;
        end
      end
      ST_MAG: begin
        state_d = ST_EVEN;
      end
      ST_EVEN: begin
        if (x_q[0] || y_q[0]) begin
          state_d = ST_GCD;
        end
      end
      ST_GCD: begin
        if (x_q == y_q) begin
          state_d = (x_q == IW'(1)) ? ST_SIGN : ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (last_bit) begin
          state_d = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (last_bit) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d       = cmd_q;
    an_d        = an_q;
    ad_d        = ad_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    step_d      = step_q;
    p_d         = p_q;
    n_d         = n_q;
    d_d         = d_q;
    x_d         = x_q;
    y_d         = y_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    neg_n_d     = neg_n_q;
    neg_d_d     = neg_d_q;
    eq_d        = eq_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_num_d   = out_num_q;
    out_den_d   = out_den_q;
    out_eq_d    = out_eq_q;
    out_err_d   = out_err_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d  = command_i;
          an_d   = a_num_i;
          ad_d   = a_den_i;
          bn_d   = b_num_i;
          bd_d   = b_den_i;
          step_d = 2'd0;
          eq_d   = 1'b0;
          err_d  = 1'b0;
          n_d    = '0;
          d_d    = IW'(1);
          if (command_i == CMD_RED) begin
            n_d = IW'(a_num_i);
            d_d = IW'(a_den_i);
          end else if (command_i == CMD_CMP) begin
            eq_d = (a_num_i == b_num_i) && (a_den_i == b_den_i);
          end
        end
      end
      ST_MUL: begin
        p_d    = prod;
        step_d = step_q + 2'd1;
        case (step_q)
          2'd1: begin
            n_d = p_ext;
          end
          2'd2: begin
            if (cmd_q == CMD_ADD) begin
              n_d = n_q + p_ext;
            end else if (cmd_q == CMD_SUB) begin
              n_d = n_q - p_ext;
            end
          end
          2'd3: begin
            d_d = p_ext;
          end
          default: begin
          end
        endcase
      end
      ST_CHECK: begin
        if (d_q == '0) begin
          err_d = 1'b1;
          n_d   = '0;
          d_d   = IW'(1);
        end else if (n_q == '0) begin
          d_d = IW'(1);
        end else if (n_q[IW-1] && d_q[IW-1]) begin
          n_d = -n_q;
          d_d = -d_q;
        end
      end
      ST_MAG: begin
        neg_n_d = n_q[IW-1];
        neg_d_d = d_q[IW-1];
        x_d     = n_q[IW-1] ? -n_q : n_q;
        y_d     = d_q[IW-1] ? -d_q : d_q;
      end
      ST_EVEN: begin
        // common powers of two leave both parts pre-divided
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
        end else begin
          n_d = x_q;
          d_d = y_q;
        end
      end
      ST_GCD: begin
        if (x_q == y_q) begin
          rem_d = '0;
          quo_d = n_q;
          cnt_d = '0;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q > y_q) begin
          x_d = diff_xy >> 1;
        end else begin
          y_d = diff_yx >> 1;
        end
      end
      ST_DIVN: begin
        rem_d = rem_next;
        quo_d = quo_next;
        cnt_d = cnt_q + CW'(1);
        if (last_bit) begin
          n_d   = quo_next;
          rem_d = '0;
          quo_d = d_q;
          cnt_d = '0;
        end
      end
      ST_DIVD: begin
        rem_d = rem_next;
        quo_d = quo_next;
        cnt_d = cnt_q + CW'(1);
        if (last_bit) begin
          d_d = quo_next;
        end
      end
      ST_SIGN: begin
        n_d = neg_n_q ? -n_q : n_q;
        d_d = neg_d_q ? -d_q : d_q;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_num_d   = OUT_W'(signed'(n_q));
          out_den_d   = OUT_W'(signed'(d_q));
          out_eq_d    = eq_q;
          out_err_d   = err_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    bn_q      <= bn_d;
    bd_q      <= bd_d;
    step_q    <= step_d;
    p_q       <= p_d;
    n_q       <= n_d;
    d_q       <= d_d;
    x_q       <= x_d;
    y_q       <= y_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
    neg_n_q   <= neg_n_d;
    neg_d_q   <= neg_d_d;
    eq_q      <= eq_d;
    err_q     <= err_d;
    out_num_q <= out_num_d;
    out_den_q <= out_den_d;
    out_eq_q  <= out_eq_d;
    out_err_q <= out_err_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign res_num_o        = out_num_q;
  assign res_den_o        = out_den_q;
  assign is_equal_o       = out_eq_q;
  assign zero_den_error_o = out_err_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// port-level properties of the rational arithmetic unit, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "rational_arith_unit_macros.svh"

module rau_checker #(
  parameter int unsigned WIDTH = 16
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic        [rau_pkg::CMD_W-1:0] command_i,
  input wire logic signed [WIDTH-1:0]          a_num_i,
  input wire logic signed [WIDTH-1:0]          a_den_i,
  input wire logic signed [WIDTH-1:0]          b_num_i,
  input wire logic signed [WIDTH-1:0]          b_den_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic signed [rau_pkg::OUT_W-1:0] res_num_o,
  input wire logic signed [rau_pkg::OUT_W-1:0] res_den_o,
  input wire logic                             is_equal_o,
  input wire logic                             zero_den_error_o
);

  import rau_pkg::*;

  logic in_accept;
  logic in_unused;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_unused = ^{command_i, a_num_i, a_den_i, b_num_i, b_den_i};

  // one item at a time: busy right after an accept
  `RAU_ASSERT(a_busy_after_accept, in_accept && !in_unused |=> in_stall_o)

  // a held result keeps its payload
  `RAU_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_num_o) && $stable(res_den_o))

  // zero numerator always comes with unit denominator
  `RAU_ASSERT(a_zero_num_unit_den, out_valid_o && res_num_o == '0 |-> res_den_o == OUT_W'(1))

  `RAU_ASSERT_ALWAYS(a_err_gives_zero,
    out_valid_o && zero_den_error_o |-> res_num_o == '0 && res_den_o == OUT_W'(1) && !is_equal_o)

  `RAU_ASSERT_ALWAYS(a_eq_gives_zero,
    out_valid_o && is_equal_o |-> res_num_o == '0 && res_den_o == OUT_W'(1) && !zero_den_error_o)

endmodule

bind rational_arith_unit rau_checker #(.WIDTH(WIDTH)) u_rau_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit testbench
// Drives signed fraction pairs with every command through the valid/stall
// input channel; checks each result against a local model of cross products,
// sign rule and gcd reduction, or a directed row's result. Directed rows
// go first, then constrained-free random items. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import rau_pkg::*;

  localparam int unsigned W = 16;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 200;
  localparam int FMAX = 32767;
  localparam int FMIN = -32768;

  typedef struct packed {
    logic signed [OUT_W-1:0] num;
    logic signed [OUT_W-1:0] den;
    logic                    eq;
    logic                    err;
  } frac_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [W-1:0]     an;
    logic [W-1:0]     ad;
    logic [W-1:0]     bn;
    logic [W-1:0]     bd;
    bit               typed;
    frac_t            res;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [CMD_W-1:0]        command;
  logic [W-1:0]            a_num;
  logic [W-1:0]            a_den;
  logic [W-1:0]            b_num;
  logic [W-1:0]            b_den;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] res_num;
  logic signed [OUT_W-1:0] res_den;
  logic                    is_equal;
  logic                    zero_den_error;

  frac_t     expected_q[$];
  stim_row_t directed[$];
  bit        calm;
  bit        cur_typed;
  frac_t     cur_res;
  int        mismatches;
  int        checked;
  int        err_seen;
  int        eq_seen;
  int        idle_cycles;
  int        cmd_seen[8];

  rational_arith_unit #(
    .WIDTH(W)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .a_num_i         (a_num),
    .a_den_i         (a_den),
    .b_num_i         (b_num),
    .b_den_i         (b_den),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .res_num_o       (res_num),
    .res_den_o       (res_den),
    .is_equal_o      (is_equal),
    .zero_den_error_o(zero_den_error)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic frac_t rational_result(logic [CMD_W-1:0] cmd,
                                            logic signed [W-1:0] an,
                                            logic signed [W-1:0] ad,
                                            logic signed [W-1:0] bn,
                                            logic signed [W-1:0] bd);
    longint n;
    longint d;
    longint x;
    longint y;
    longint t;
    bit     arith;
    frac_t  r;
    n = 0;
    d = 1;
    r.eq = 1'b0;
    r.err = 1'b0;
    arith = 1'b1;
    case (cmd)
      CMD_ADD: begin
        n = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
        d = longint'(ad) * longint'(bd);
      end
      CMD_SUB: begin
        n = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
        d = longint'(ad) * longint'(bd);
      end
      CMD_MUL: begin
        n = longint'(an) * longint'(bn);
        d = longint'(ad) * longint'(bd);
      end
      CMD_DIV: begin
        n = longint'(an) * longint'(bd);
        d = longint'(ad) * longint'(bn);
      end
      CMD_RED: begin
        n = longint'(an);
        d = longint'(ad);
      end
      CMD_CMP: begin
        r.eq = (an == bn) && (ad == bd);
        arith = 1'b0;
      end
      default: begin
        arith = 1'b0;
      end
    endcase
    if (!arith) begin
      n = 0;
      d = 1;
    end else if (d == 0) begin
      r.err = 1'b1;
      n = 0;
      d = 1;
    end else begin
      if (n == 0) d = 1;
      if (n < 0 && d < 0) begin
        n = -n;
        d = -d;
      end
      if (n != 0) begin
        x = (n < 0) ? -n : n;
        y = (d < 0) ? -d : d;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        if (x > 1) begin
          n = n / x;
          d = d / x;
        end
      end
    end
    r.num = n[OUT_W-1:0];
    r.den = d[OUT_W-1:0];
    return r;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    if (got !== want)
      report($sformatf("%s expected %0d got %0d", name, $signed(want), $signed(got)));
  endtask

  always @(posedge clk) begin : result_monitor
    frac_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        checked++;
        if (zero_den_error) err_seen++;
        if (is_equal) eq_seen++;
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result %0d/%0d", res_num, res_den));
        end else begin
          want = expected_q.pop_front();
          check_field("res_num", want.num, res_num);
          check_field("res_den", want.den, res_den);
          check_field("is_equal", OUT_W'(want.eq), OUT_W'(is_equal));
          check_field("zero_den_error", OUT_W'(want.err), OUT_W'(zero_den_error));
        end
      end
      if (in_valid && !in_stall) begin
        cmd_seen[command]++;
        if (cur_typed) expected_q.push_back(cur_res);
        else expected_q.push_back(rational_result(command, a_num, a_den, b_num, b_den));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : result_stall
    int k;
    forever begin
      k = calm ? 0 : $urandom_range(0, 4);
      if (k != 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic add_row(logic [CMD_W-1:0] cmd, int an, int ad, int bn, int bd,
                         bit typed = 1'b0, longint num = 0, longint den = 1,
                         bit eq = 1'b0, bit err = 1'b0);
    stim_row_t row;
    row.cmd = cmd;
    row.an = an[W-1:0];
    row.ad = ad[W-1:0];
    row.bn = bn[W-1:0];
    row.bd = bd[W-1:0];
    row.typed = typed;
    row.res.num = num[OUT_W-1:0];
    row.res.den = den[OUT_W-1:0];
    row.res.eq = eq;
    row.res.err = err;
    directed.push_back(row);
  endtask

  task automatic send(stim_row_t row);
    int k;
    k = calm ? 0 : $urandom_range(0, 4);
    if (k != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command <= row.cmd;
    a_num <= row.an;
    a_den <= row.ad;
    b_num <= row.bn;
    b_den <= row.bd;
    cur_typed = row.typed;
    cur_res = row.res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [W-1:0] rand_field();
    logic [W-1:0] v;
    int           s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = W'($urandom);
      4, 5, 6: begin
        s = $urandom_range(0, 40);
        v = W'(s - 20);
      end
      7: begin
        case ($urandom_range(0, 3))
          0: v = W'(FMAX);
          1: v = W'(FMIN);
          2: v = W'(1);
          default: v = W'(-1);
        endcase
      end
      8: begin
        v = W'($urandom_range(1, 15)) << $urandom_range(0, 11);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t row;
    int        c;
    c = $urandom_range(0, 19);
    if (c >= 18) row.cmd = (c == 18) ? CMD_SPARE6 : CMD_SPARE7;
    else row.cmd = CMD_W'(c % 6);
    row.an = rand_field();
    row.ad = rand_field();
    row.bn = rand_field();
    row.bd = rand_field();
    if (row.cmd == CMD_CMP) begin
      case ($urandom_range(0, 3))
        0: begin
          row.bn = row.an;
          row.bd = row.ad;
        end
        1: row.bn = row.an;
        2: row.bd = row.ad;
        default: ;
      endcase
    end
    row.typed = 1'b0;
    row.res = '0;
    return row;
  endfunction

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    command = '0;
    a_num = '0;
    a_den = '0;
    b_num = '0;
    b_den = '0;
    calm = 1'b0;
    cur_typed = 1'b0;
    cur_res = '0;
    mismatches = 0;
    checked = 0;
    err_seen = 0;
    eq_seen = 0;
    idle_cycles = 0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;

    add_row(CMD_CMP, 7, -3, 7, -3, 1'b1, 0, 1, 1'b1, 1'b0);
    add_row(CMD_CMP, FMIN, FMAX, FMIN, FMIN, 1'b1, 0, 1, 1'b0, 1'b0);
    add_row(CMD_RED, 0, 5, 9, 9, 1'b1, 0, 1);
    add_row(CMD_RED, 6, 4, 0, 0, 1'b1, 3, 2);
    add_row(CMD_RED, -3, -6, 1, 1, 1'b1, 1, 2);
    add_row(CMD_RED, 3, -6, 1, 1, 1'b1, 1, -2);
    add_row(CMD_RED, 5, 0, 1, 1, 1'b1, 0, 1, 1'b0, 1'b1);
    add_row(CMD_RED, 0, 0, 1, 1, 1'b1, 0, 1, 1'b0, 1'b1);
    add_row(CMD_DIV, 1, 2, 0, 3, 1'b1, 0, 1, 1'b0, 1'b1);
    add_row(CMD_ADD, 1, 0, 1, 1, 1'b1, 0, 1, 1'b0, 1'b1);
    add_row(CMD_SPARE6, 3, 4, 5, 6, 1'b1, 0, 1);
    add_row(CMD_SPARE7, FMIN, 0, FMAX, 0, 1'b1, 0, 1);
    add_row(CMD_MUL, FMIN, FMIN, FMIN, FMIN, 1'b1, 1, 1);
    add_row(CMD_ADD, FMAX, 1, FMAX, 1, 1'b1, 65534, 1);
    add_row(CMD_SUB, FMIN, 1, FMAX, 1, 1'b1, -65535, 1);
    add_row(CMD_ADD, FMIN, 1, FMIN, 1, 1'b1, -65536, 1);
    add_row(CMD_SUB, 5, 7, 5, 7, 1'b1, 0, 1);
    add_row(CMD_ADD, 1, 3, 1, 6);
    add_row(CMD_DIV, FMIN, FMAX, FMAX, FMIN);
    add_row(CMD_MUL, FMAX, FMIN, FMIN, -1);
    add_row(CMD_ADD, FMAX, FMIN, FMIN, FMAX);
    add_row(CMD_SUB, -1, -1, FMAX, FMIN);
    add_row(CMD_DIV, -4, 6, -2, -9);
    add_row(CMD_MUL, -1, FMAX, 1, FMAX);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send(directed[i]);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_results();
      calm = ((i / 150) % 4) == 3;
      send(rand_row());
    end
    calm = 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0)
      report($sformatf("%0d results never arrived", expected_q.size()));

    $display("items by command: add %0d sub %0d mul %0d div %0d cmp %0d reduce %0d spare %0d",
             cmd_seen[CMD_ADD], cmd_seen[CMD_SUB], cmd_seen[CMD_MUL], cmd_seen[CMD_DIV],
             cmd_seen[CMD_CMP], cmd_seen[CMD_RED], cmd_seen[CMD_SPARE6] + cmd_seen[CMD_SPARE7]);
    $display("%0d results checked, %0d zero denominators, %0d equal compares, %0d mismatches",
             checked, err_seen, eq_seen, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
